[rtl/unicycle_pose_integrator_unit_macros.svh]
// Assertion macros shared by the unicycle pose integrator RTL.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef UNICYCLE_POSE_INTEGRATOR_UNIT_MACROS_SVH
`define UNICYCLE_POSE_INTEGRATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define UPI_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define UPI_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/upi_pkg.sv]
// Package for the unicycle pose integrator: payload types, CORDIC table and
// fixed-point constants. No dependencies.
package upi_pkg;

    localparam int ANGLE_BITS_DEF = 16;

    localparam int CORDIC_STEPS = 30;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);

    // Operand and product widths of the shared multiplier.
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // round(2^24 / (2*pi)): radians in Q.24 to turns in Q.48.
    localparam logic [21:0] TURNS_PER_RAD_Q24 = 22'd2670177;

    // Reciprocal of the CORDIC gain in Q2.30.
    localparam logic signed [MUL_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] cmd_linear;
        logic signed [31:0] cmd_angular;
        logic        [15:0] step_time;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic        [15:0] pose_heading;
    } upi_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] heading;
        logic signed [31:0] lin_speed;
        logic signed [31:0] ang_speed;
    } upi_result_t;

endpackage

[rtl/upi_item_if.sv]
// Valid/ready channel carrying one input item of the pose integrator.
// Depends on upi_pkg for the payload type.
interface upi_item_if import upi_pkg::*; ();

    logic      valid;
    logic      ready;
    upi_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

[rtl/upi_result_if.sv]
// Valid/ready channel carrying one result item of the pose integrator.
// Depends on upi_pkg for the payload type.
interface upi_result_if import upi_pkg::*; ();

    logic        valid;
    logic        ready;
    upi_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

[rtl/unicycle_pose_integrator_unit.sv]
// Unicycle pose integrator: Euler dead reckoning with a shared multiplier
// and an iterative CORDIC. Depends on upi_pkg, upi_item_if, upi_result_if
// and unicycle_pose_integrator_unit_macros.svh.
//
//   Channel   Direction  Payload        Transfer when
//   item      in         upi_item_t     item.valid && item.ready
//   result    out        upi_result_t   result.valid && result.ready
//
// A load item goes to S_DONE and is written to the result register from there.
// A tick item first updates the heading, then runs the iterative CORDIC at
// one step per cycle, then updates position and speeds, passing through the
// single 34x34 multiplier and its rounding, before it reaches S_DONE.
// A new item is taken only in S_IDLE, entered once the previous result is
// registered, so none is taken before the last is done. The block waits with
// a finished item while the result register holds a result not transferred.
// Reset clears pose, speeds and control; there is no clearing pass.
`include "unicycle_pose_integrator_unit_macros.svh"

module unicycle_pose_integrator_unit import upi_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    upi_item_if.sink         item,
    upi_result_if.source     result
);

    localparam int HEAD_SHIFT = 48 - ANGLE_BITS;
    localparam int CORDIC_PAD = 32 - ANGLE_BITS;

    typedef enum logic [17:0] {
        S_IDLE    = 18'h00001,
        S_H_MWD   = 18'h00002,
        S_H_RND   = 18'h00004,
        S_H_MLO   = 18'h00008,
        S_H_MHI   = 18'h00010,
        S_H_UPD   = 18'h00020,
        S_C_INIT  = 18'h00040,
        S_C_ITER  = 18'h00080,
        S_X_MTRIG = 18'h00100,
        S_X_RND   = 18'h00200,
        S_X_MDT   = 18'h00400,
        S_X_UPD   = 18'h00800,
        S_Y_RND   = 18'h01000,
        S_Y_MDT   = 18'h02000,
        S_Y_UPD   = 18'h04000,
        S_L_UPD   = 18'h08000,
        S_A_UPD   = 18'h10000,
        S_DONE    = 18'h20000
    } upi_state_t;

    upi_state_t state_reg, state_next;

    logic signed [31:0]        x_pos_reg, x_pos_next;
    logic signed [31:0]        y_pos_reg, y_pos_next;
    logic [ANGLE_BITS-1:0]     heading_reg, heading_next;
    logic signed [31:0]        lin_speed_reg, lin_speed_next;
    logic signed [31:0]        ang_speed_reg, ang_speed_next;

    logic [15:0]               dt_reg, dt_next;
    logic signed [32:0]        diff_lin_reg, diff_lin_next;
    logic signed [32:0]        diff_ang_reg, diff_ang_next;
    logic signed [39:0]        r_reg, r_next;
    logic [47:0]               acc_reg, acc_next;
    logic signed [MUL_W-1:0]   a_reg, a_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;

    logic signed [MUL_W-1:0]   cx_reg, cx_next;
    logic signed [MUL_W-1:0]   cy_reg, cy_next;
    logic signed [32:0]        cz_reg, cz_next;
    logic                      flip_reg, flip_next;
    logic [ITER_W-1:0]         iter_reg, iter_next;

    upi_result_t               res_reg, res_next;
    logic                      res_valid_reg, res_valid_next;

    logic                      item_xfer;
    logic                      res_free;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [MUL_W-1:0]   dt_op;

    logic [47:0]               p_rnd;
    logic [47:0]               t48;
    logic [47:0]               t_rnd;
    logic [PROD_W-1:0]         trig_sel;
    logic [PROD_W-1:0]         trig_rnd;
    logic [47:0]               d_rnd;
    logic [31:0]               step_d;
    logic [31:0]               a32;
    logic signed [31:0]        z_turn;
    logic                      z_flip;
    logic [31:0]               z_init;
    logic signed [MUL_W-1:0]   dx, dy;
    logic signed [32:0]        atan_op;
    logic [31:0]               pose_head_ext;
    logic [31:0]               head_ext;

    assign item.ready    = (state_reg == S_IDLE);
    assign item_xfer     = item.valid && item.ready;
    assign res_free      = !res_valid_reg || result.ready;
    assign result.valid  = res_valid_reg;
    assign result.data   = res_reg;

    assign dt_op = $signed({18'b0, dt_reg});

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_H_MWD:
            begin
                mul_a = MUL_W'(ang_speed_reg);
                mul_b = dt_op;
            end
            S_H_MLO:
            begin
                mul_a = $signed({18'b0, r_reg[15:0]});
                mul_b = $signed({12'b0, TURNS_PER_RAD_Q24});
            end
            S_H_MHI:
            begin
                mul_a = MUL_W'($signed(r_reg[39:16]));
                mul_b = $signed({12'b0, TURNS_PER_RAD_Q24});
            end
            S_X_MTRIG:
            begin
                mul_a = MUL_W'(lin_speed_reg);
                mul_b = cx_reg;
            end
            S_X_UPD:
            begin
                mul_a = MUL_W'(lin_speed_reg);
                mul_b = cy_reg;
            end
            S_X_MDT, S_Y_MDT:
            begin
                mul_a = a_reg;
                mul_b = dt_op;
            end
            S_Y_UPD:
            begin
                mul_a = MUL_W'(diff_lin_reg);
                mul_b = dt_op;
            end
            S_L_UPD:
            begin
                mul_a = MUL_W'(diff_ang_reg);
                mul_b = dt_op;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Rounding of the registered product for each kind of step. Only the low
    // 48 bits of the heading term matter since the angle wraps.
    assign p_rnd    = prod_reg[47:0] + 48'd128;
    assign t48      = acc_reg + {prod_reg[31:0], 16'b0};
    assign t_rnd    = t48 + (48'd1 << (HEAD_SHIFT - 1));
    assign trig_sel = flip_reg ? ~prod_reg : prod_reg;
    assign trig_rnd = trig_sel + (flip_reg ? PROD_W'(33'h20000001) : PROD_W'(33'h20000000));
    assign d_rnd    = prod_reg[47:0] + 48'd32768;
    assign step_d   = d_rnd[47:16];

    // Fold the angle into the right half plane; the results are negated later.
    assign a32    = {heading_reg, {CORDIC_PAD{1'b0}}};
    assign z_turn = $signed(a32);
    assign z_flip = (z_turn > 32'sh40000000) || (z_turn < -32'sh40000000);
    assign z_init = z_flip ? {~a32[31], a32[30:0]} : a32;

    assign dx      = cy_reg >>> iter_reg;
    assign dy      = cx_reg >>> iter_reg;
    assign atan_op = $signed({1'b0, ATAN_TURNS[iter_reg]});

    assign pose_head_ext = 32'(item.data.pose_heading);
    assign head_ext      = 32'(heading_reg);

    always_comb
    begin
        state_next     = state_reg;
        x_pos_next     = x_pos_reg;
        y_pos_next     = y_pos_reg;
        heading_next   = heading_reg;
        lin_speed_next = lin_speed_reg;
        ang_speed_next = ang_speed_reg;
        dt_next        = dt_reg;
        diff_lin_next  = diff_lin_reg;
        diff_ang_next  = diff_ang_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        a_next         = a_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        flip_next      = flip_reg;
        iter_next      = iter_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;

        if (result.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    if (item.data.operation == OP_LOAD)
                    begin
                        x_pos_next   = item.data.pose_x;
                        y_pos_next   = item.data.pose_y;
                        heading_next = pose_head_ext[ANGLE_BITS-1:0];
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        dt_next       = item.data.step_time;
                        diff_lin_next = 33'(item.data.cmd_linear) - 33'(lin_speed_reg);
                        diff_ang_next = 33'(item.data.cmd_angular) - 33'(ang_speed_reg);
                        state_next    = S_H_MWD;
                    end
                end
            end
            S_H_MWD:
            begin
                state_next = S_H_RND;
            end
            S_H_RND:
            begin
                r_next     = $signed(p_rnd[47:8]);
                state_next = S_H_MLO;
            end
            S_H_MLO:
            begin
                state_next = S_H_MHI;
            end
            S_H_MHI:
            begin
                acc_next   = prod_reg[47:0];
                state_next = S_H_UPD;
            end
            S_H_UPD:
            begin
                heading_next = heading_reg + t_rnd[47:HEAD_SHIFT];
                state_next   = S_C_INIT;
            end
            S_C_INIT:
            begin
                cx_next    = CORDIC_INV_GAIN;
                cy_next    = '0;
                cz_next    = 33'($signed(z_init));
                flip_next  = z_flip;
                iter_next  = '0;
                state_next = S_C_ITER;
            end
            S_C_ITER:
            begin
                if (!cz_reg[32])
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - atan_op;
                end
                else
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + atan_op;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_X_MTRIG;
                end
            end
            S_X_MTRIG:
            begin
                state_next = S_X_RND;
            end
            S_X_RND:
            begin
                a_next     = $signed(trig_rnd[63:30]);
                state_next = S_X_MDT;
            end
            S_X_MDT:
            begin
                state_next = S_X_UPD;
            end
            S_X_UPD:
            begin
                x_pos_next = x_pos_reg + $signed(step_d);
                state_next = S_Y_RND;
            end
            S_Y_RND:
            begin
                a_next     = $signed(trig_rnd[63:30]);
                state_next = S_Y_MDT;
            end
            S_Y_MDT:
            begin
                state_next = S_Y_UPD;
            end
            S_Y_UPD:
            begin
                y_pos_next = y_pos_reg + $signed(step_d);
                state_next = S_L_UPD;
            end
            S_L_UPD:
            begin
                lin_speed_next = lin_speed_reg + $signed(step_d);
                state_next     = S_A_UPD;
            end
            S_A_UPD:
            begin
                ang_speed_next = ang_speed_reg + $signed(step_d);
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    res_next.pos_x     = x_pos_reg;
                    res_next.pos_y     = y_pos_reg;
                    res_next.heading   = head_ext[15:0];
                    res_next.lin_speed = lin_speed_reg;
                    res_next.ang_speed = ang_speed_reg;
                    res_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            x_pos_reg     <= '0;
            y_pos_reg     <= '0;
            heading_reg   <= '0;
            lin_speed_reg <= '0;
            ang_speed_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            x_pos_reg     <= x_pos_next;
            y_pos_reg     <= y_pos_next;
            heading_reg   <= heading_next;
            lin_speed_reg <= lin_speed_next;
            ang_speed_reg <= ang_speed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg       <= dt_next;
        diff_lin_reg <= diff_lin_next;
        diff_ang_reg <= diff_ang_next;
        r_reg        <= r_next;
        acc_reg      <= acc_next;
        a_reg        <= a_next;
        prod_reg     <= prod_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        flip_reg     <= flip_next;
        iter_reg     <= iter_next;
        res_reg      <= res_next;
    end

    `UPI_ASSERT_IMPLY(a_iter_range, state_reg == S_C_ITER, iter_reg < ITER_W'(CORDIC_STEPS), "CORDIC step count out of range")
    `UPI_ASSERT_NEXT(a_load_done, item_xfer && (item.data.operation == OP_LOAD), state_reg == S_DONE, "load item did not go straight to result")
    `UPI_ASSERT_NEXT(a_head_hold, state_reg == S_C_ITER, $stable(heading_reg), "heading changed during CORDIC")
    `UPI_ASSERT_IMPLY(a_res_hold, $fell(res_valid_reg), $past(result.ready), "result dropped without a transfer")

endmodule

[dv/unicycle_pose_integrator_unit_tb.sv]
// Self-checking testbench for unicycle_pose_integrator_unit: directed pose and tick
// items, then random traffic under varying backpressure, checked by a scoreboard.
// Depends on upi_pkg, upi_item_if, upi_result_if and the RTL of the block.
`timescale 1ns / 100ps

module unicycle_pose_integrator_unit_tb import upi_pkg::*; ;

    localparam int ANGLE_BITS   = ANGLE_BITS_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 330;

    // Tracks the pose and speeds the block should hold and the results still owed.
    class pose_scoreboard;
        logic signed [31:0]    cur_x;
        logic signed [31:0]    cur_y;
        logic [ANGLE_BITS-1:0] cur_heading;
        logic signed [31:0]    cur_lin;
        logic signed [31:0]    cur_ang;
        upi_result_t           expected_poses[$];
        int                    mismatches;

        function new();
            cur_x       = '0;
            cur_y       = '0;
            cur_heading = '0;
            cur_lin     = '0;
            cur_ang     = '0;
            mismatches  = 0;
        endfunction

        // Add half an LSB, then floor.
        function longint round_shr(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        // Rotation-mode CORDIC on a 32-bit turn, folded into the right half plane.
        function void unit_circle(logic [ANGLE_BITS-1:0] ang, output longint c,
                                  output longint s);
            logic signed [31:0] turn32;
            longint z;
            longint px;
            longint py;
            longint dx;
            longint dy;
            bit     flip;
            turn32 = {ang, {(32 - ANGLE_BITS){1'b0}}};
            z      = turn32;
            px     = CORDIC_INV_GAIN;
            py     = 0;
            flip   = 1'b0;
            if (z > (longint'(1) << 30)) begin
                z    = z - (longint'(1) << 31);
                flip = 1'b1;
            end
            else if (z < -(longint'(1) << 30)) begin
                z    = z + (longint'(1) << 31);
                flip = 1'b1;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = py >>> i;
                dy = px >>> i;
                if (z >= 0) begin
                    px = px - dx;
                    py = py + dy;
                    z  = z - longint'(ATAN_TURNS[i]);
                end
                else begin
                    px = px + dx;
                    py = py - dy;
                    z  = z + longint'(ATAN_TURNS[i]);
                end
            end
            c = flip ? -px : px;
            s = flip ? -py : py;
        endfunction

        function logic signed [31:0] toward(logic signed [31:0] now,
                                            logic signed [31:0] goal, longint dt);
            longint cur_v;
            longint diff;
            cur_v = now;
            diff  = longint'(goal) - cur_v;
            return 32'(cur_v + round_shr(diff * dt, 16));
        endfunction

        function void note_item(upi_item_t it);
            longint      dt;
            longint      w;
            longint      v;
            longint      r;
            longint      t;
            longint      delta;
            longint      c;
            longint      s;
            upi_result_t pose;
            if (it.operation == OP_LOAD) begin
                cur_x       = it.pose_x;
                cur_y       = it.pose_y;
                cur_heading = ANGLE_BITS'(it.pose_heading);
            end
            else begin
                dt    = longint'(it.step_time);
                w     = cur_ang;
                v     = cur_lin;
                r     = round_shr(w * dt, 8);
                t     = r * longint'(TURNS_PER_RAD_Q24);
                delta = round_shr(t, 48 - ANGLE_BITS);
                // The position step uses the new heading but the old speeds.
                cur_heading = cur_heading + ANGLE_BITS'(delta);
                unit_circle(cur_heading, c, s);
                cur_x   = cur_x + 32'(round_shr(round_shr(v * c, 30) * dt, 16));
                cur_y   = cur_y + 32'(round_shr(round_shr(v * s, 30) * dt, 16));
                cur_lin = toward(cur_lin, it.cmd_linear, dt);
                cur_ang = toward(cur_ang, it.cmd_angular, dt);
            end
            pose.pos_x     = cur_x;
            pose.pos_y     = cur_y;
            pose.heading   = 16'(cur_heading);
            pose.lin_speed = cur_lin;
            pose.ang_speed = cur_ang;
            expected_poses = {expected_poses, pose};
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(upi_result_t got);
            upi_result_t want;
            if (expected_poses.size() == 0) begin
                $error("result transfer with no expected pose pending");
                mismatches++;
                return;
            end
            want = expected_poses.pop_front();
            check_field("pos_x", want.pos_x, got.pos_x);
            check_field("pos_y", want.pos_y, got.pos_y);
            check_field("heading", want.heading, got.heading);
            check_field("lin_speed", want.lin_speed, got.lin_speed);
            check_field("ang_speed", want.ang_speed, got.ang_speed);
        endfunction

        function int pending();
            return expected_poses.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    int          send_idle_pct = 13;
    int          recv_idle_pct = 46;
    int unsigned cycle_count   = 0;

    pose_scoreboard pose_sb = new();

    upi_item_if   item_bus();
    upi_result_if result_bus();

    unicycle_pose_integrator_unit #(
        .ANGLE_BITS (ANGLE_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_item(input upi_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.data  <= it;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        pose_sb.note_item(it);
    endtask

    // Pose fields are ignored on a tick, so they carry noise.
    task automatic send_tick(input logic signed [31:0] lin, input logic signed [31:0] ang,
                             input logic [15:0] dt);
        upi_item_t it;
        it.operation    = OP_TICK;
        it.cmd_linear   = lin;
        it.cmd_angular  = ang;
        it.step_time    = dt;
        it.pose_x       = $urandom;
        it.pose_y       = $urandom;
        it.pose_heading = 16'($urandom);
        send_item(it);
    endtask

    // Commands and step time are ignored on a load, so they carry noise.
    task automatic send_load(input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic [15:0] ph);
        upi_item_t it;
        it.operation    = OP_LOAD;
        it.cmd_linear   = $urandom;
        it.cmd_angular  = $urandom;
        it.step_time    = 16'($urandom);
        it.pose_x       = px;
        it.pose_y       = py;
        it.pose_heading = ph;
        send_item(it);
    endtask

    function automatic logic signed [31:0] random_speed();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 32'sh7FFFFFFF;
        else if (pick == 1)
            return 32'sh80000000;
        else if (pick < 6)
            return $signed($urandom_range(1310720)) - 32'sd655360;
        else
            return $urandom;
    endfunction

    function automatic upi_item_t random_item();
        upi_item_t it;
        int        pick;
        it.operation   = ($urandom_range(9) == 0) ? OP_LOAD : OP_TICK;
        it.cmd_linear  = random_speed();
        it.cmd_angular = random_speed();
        pick = $urandom_range(9);
        if (pick == 0)
            it.step_time = 16'h0000;
        else if (pick == 1)
            it.step_time = 16'hFFFF;
        else if (pick < 6)
            it.step_time = 16'($urandom_range(1000));
        else
            it.step_time = 16'($urandom);
        it.pose_x       = $urandom;
        it.pose_y       = $urandom;
        it.pose_heading = 16'($urandom);
        return it;
    endfunction

    // Results are checked on the values seen at the edge, then ready is redrawn.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
                pose_sb.check_result(result_bus.data);
            result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
        else
        begin
            result_bus.ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL unicycle_pose_integrator_unit");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] quarter_marks [8];
        quarter_marks = '{16'h0000, 16'h3FFF, 16'h4000, 16'h4001,
                          16'h8000, 16'hBFFF, 16'hC000, 16'hC001};

        rst_n            = 1'b0;
        item_bus.valid   = 1'b0;
        item_bus.data    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A zero step leaves the reset state untouched.
        send_tick(32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'h0000);
        // Full-length steps drive both speeds close to their extreme commands.
        send_tick(32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF);
        send_tick(32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF);
        // Start next to the edges of the position range so the next moves wrap.
        send_load(32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF);
        send_tick(32'sh7FFFFFFF, 32'sh00000000, 16'hFFFF);
        send_tick(32'sh7FFFFFFF, 32'sh00000000, 16'hFFFF);
        send_tick(32'sh7FFFFFFF, 32'sh00000000, 16'hFFFF);
        // Headings on and around the quadrant boundaries of the sine/cosine fold.
        foreach (quarter_marks[k])
        begin
            send_load(32'sh00000000, 32'sh00000000, quarter_marks[k]);
            send_tick(32'sh00010000, 32'sh00000000, 16'h0100);
        end
        send_tick(32'sh80000000, 32'sh00010000, 16'hFFFF);
        send_load(32'sh80000000, 32'sh7FFFFFFF, 16'h0000);

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 13;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (RANDOM_ITEMS)
                send_item(random_item());
        end

        item_bus.valid <= 1'b0;
        while (pose_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pose_sb.mismatches == 0)
            $display("PASS unicycle_pose_integrator_unit");
        else
            $display("FAIL unicycle_pose_integrator_unit");
        $finish;
    end

endmodule
